// ----- rtl/core/ddm_pkg.sv -----
package ddm_pkg;

  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 2;
  localparam int GAP_BITS     = 4;
  localparam int ROW_BITS     = 11;
  localparam int OUT_BITS     = 10;

  localparam logic [ROW_BITS-1:0] MAX_HEIGHT = 11'd1024;

  localparam logic [GAP_BITS-1:0] GAP_RESET    = 4'd1;
  localparam logic                STRONG_RESET = 1'b0;
  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd480;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GAP,
    CFG_STRONG,
    CFG_WIDTH,
    CFG_HEIGHT
  } cfg_idx_t;

  // per-item control word from the position tracker
  typedef struct packed {
    logic                advance;
    logic                has_out;
    logic                border_ok;
    logic                frame_end;
    logic [OUT_BITS-1:0] row;
    logic [OUT_BITS-1:0] col;
  } ddm_pos_t;

endpackage

// ----- rtl/core/ddm_in_if.sv -----
interface ddm_in_if #(
  parameter int PIXEL_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output kind, output pixel, input ready);
  modport sink (input valid, input kind, input pixel, output ready);
endinterface

// ----- rtl/core/ddm_out_if.sv -----
interface ddm_out_if #(
  parameter int DIFF_BITS = 18
);
  logic                        valid;
  logic                        ready;
  logic [9:0]                  out_row;
  logic [9:0]                  out_col;
  logic signed [DIFF_BITS-1:0] diff_value;
  logic                        frame_end;

  modport source (output valid, output out_row, output out_col, output diff_value,
                  output frame_end, input ready);
  modport sink (input valid, input out_row, input out_col, input diff_value,
                input frame_end, output ready);
endinterface

// ----- rtl/core/ddm_ram.sv -----
module ddm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-cycle collision
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- rtl/core/ddm_pos.sv -----
module ddm_pos #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_GAP = 8,
  localparam int COL_BITS = $clog2(MAX_WIDTH),
  localparam int RING_BITS = $clog2(2 * MAX_GAP),
  localparam int ADDR_BITS = RING_BITS + COL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ddm_pkg::GAP_BITS-1:0]   gap,
  input  logic [ddm_pkg::CFG_BITS-1:0]   frame_width,
  input  logic [ddm_pkg::CFG_BITS-1:0]   frame_height,
  input  logic                           fire,
  input  logic                           kind,
  output logic [ddm_pkg::GAP_BITS-1:0]   gap_eff,
  output ddm_pkg::ddm_pos_t              info,
  output logic                           wr_en,
  output logic [ADDR_BITS-1:0]           wr_addr,
  output logic [ADDR_BITS-1:0]           rd_right_addr,
  output logic [ADDR_BITS-1:0]           rd_up_addr
);
  import ddm_pkg::*;

  localparam int WB = ($clog2(MAX_WIDTH + 1) > CFG_BITS) ? $clog2(MAX_WIDTH + 1) : CFG_BITS;
  localparam int SW = WB + 1;
  localparam logic [WB-1:0] W_CAP = WB'(MAX_WIDTH);
  localparam logic [GAP_BITS-1:0] G_CAP = (MAX_GAP < 15) ? GAP_BITS'(MAX_GAP) : '1;

  logic [GAP_BITS-1:0] g;
  logic [WB-1:0]       w;
  logic [ROW_BITS-1:0] h;
  logic [ROW_BITS-1:0] in_row, in_row_next;
  logic [COL_BITS-1:0] in_col, in_col_next;
  logic [ROW_BITS-1:0] r0, r, ro, ro_up, ro_dn;
  logic [COL_BITS-1:0] c0, c;
  logic [SW-1:0]       c_right, c_wrap, c_inc;
  logic                ignore, excess, adv, has_out, fe;

  always_comb begin
    g = (gap > G_CAP) ? G_CAP : gap;
    if (frame_width == '0) w = WB'(1);
    else if (WB'(frame_width) > W_CAP) w = W_CAP;
    else w = WB'(frame_width);
    if (frame_height == '0) h = ROW_BITS'(1);
    else if (frame_height > MAX_HEIGHT) h = MAX_HEIGHT;
    else h = frame_height;

    // a column left past a narrowed width moves on to the next row
    if (WB'(in_col) >= w) begin
      r0 = in_row + ROW_BITS'(1);
      c0 = '0;
    end else begin
      r0 = in_row;
      c0 = in_col;
    end

    ignore = kind && (r0 < h);
    excess = kind && (r0 >= h + ROW_BITS'(g));
    if (!kind && (r0 >= h)) begin
      r = '0;
      c = '0;
    end else begin
      r = r0;
      c = c0;
    end

    adv     = !ignore && !excess;
    has_out = adv && (r >= ROW_BITS'(g));
    ro      = r - ROW_BITS'(g);
    ro_up   = ro - ROW_BITS'(g);
    ro_dn   = ro + ROW_BITS'(1);
    c_right = SW'(c) + SW'(g);
    c_wrap  = c_right - SW'(w);
    c_inc   = SW'(c) + SW'(1);
    fe      = (ro == h - ROW_BITS'(1)) && (SW'(c) == SW'(w) - SW'(1));

    info.advance   = adv;
    info.has_out   = has_out;
    info.border_ok = has_out && (g != '0) && (ro >= ROW_BITS'(g)) && (r < h)
                     && (c >= COL_BITS'(g)) && (c_right < SW'(w));
    info.frame_end = has_out && fe;
    info.row       = ro[OUT_BITS-1:0];
    info.col       = OUT_BITS'(c);

    wr_en   = fire && !kind;
    wr_addr = {r[RING_BITS-1:0], c};
    // lookahead tap runs on in raster order across the row end
    if (c_right < SW'(w)) rd_right_addr = {ro[RING_BITS-1:0], c_right[COL_BITS-1:0]};
    else rd_right_addr = {ro_dn[RING_BITS-1:0], c_wrap[COL_BITS-1:0]};
    rd_up_addr = {ro_up[RING_BITS-1:0], c};

    in_row_next = in_row;
    in_col_next = in_col;
    if (fire) begin
      if (ignore) begin
        in_row_next = r0;
        in_col_next = c0;
      end else if (excess || (has_out && fe)) begin
        in_row_next = '0;
        in_col_next = '0;
      end else if (c_inc >= SW'(w)) begin
        in_row_next = r + ROW_BITS'(1);
        in_col_next = '0;
      end else begin
        in_row_next = r;
        in_col_next = c_inc[COL_BITS-1:0];
      end
    end
  end

  assign gap_eff = g;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
    end else begin
      in_row <= in_row_next;
      in_col <= in_col_next;
    end
  end

endmodule

// ----- rtl/core/directional_diff_map.sv -----
// Directional second-difference filter for a raster stream of signed pixels. For each
// pixel it forms the vertical difference (2p minus the pixels gap rows above and below)
// and the horizontal one (2p minus the pixels gap columns left and right), and returns
// the one of smaller magnitude, or of larger magnitude when strong_mode is set; a tie
// takes the horizontal one. Pixels within gap of a frame edge give 0. A result trails
// its input by gap rows, so gap rows of drain items (kind = 1) flush the frame after its
// last pixel. The block takes one item per clock unless the output stalls: the line
// store is a single RAM that takes one pixel write and two reads (lookahead tap of the
// output row, and the row gap above it) each cycle, and a short row window supplies the
// center and left taps. A taken item passes the read stage and the difference stage
// before its result reaches the output register. The line store holds no reset state and
// needs no clearing after reset. Write the registers only while the block is idle.
module directional_diff_map #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_GAP = 8,
  parameter int PIXEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ddm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ddm_pkg::CFG_BITS-1:0]     cfg_data,
  ddm_in_if.sink                           pixels,
  ddm_out_if.source                        results
);
  import ddm_pkg::*;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int RING_BITS = $clog2(2 * MAX_GAP);
  localparam int ADDR_BITS = RING_BITS + COL_BITS;
  localparam int DEPTH     = 1 << ADDR_BITS;
  localparam int WIN_DEPTH = 1 << RING_BITS;
  localparam int IW        = (RING_BITS > GAP_BITS + 1) ? RING_BITS : GAP_BITS + 1;
  localparam int DW        = PIXEL_BITS + 2;

  logic [GAP_BITS-1:0] gap;
  logic                strong_mode;
  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap          <= GAP_RESET;
      strong_mode  <= STRONG_RESET;
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAP:    gap <= cfg_data[GAP_BITS-1:0];
        CFG_STRONG: strong_mode <= cfg_data[0];
        CFG_WIDTH:  frame_width <= cfg_data;
        CFG_HEIGHT: frame_height <= cfg_data;
      endcase
    end
  end

  logic                 in_fire;
  logic [GAP_BITS-1:0]  gap_eff;
  ddm_pos_t             pos_info;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr, rd_right_addr, rd_up_addr;
  logic [PIXEL_BITS-1:0] q_right, q_up;

  ddm_pos #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_GAP(MAX_GAP)
  ) u_pos (
    .clk(clk),
    .rst(rst),
    .gap(gap),
    .frame_width(frame_width),
    .frame_height(frame_height),
    .fire(in_fire),
    .kind(pixels.kind),
    .gap_eff(gap_eff),
    .info(pos_info),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .rd_right_addr(rd_right_addr),
    .rd_up_addr(rd_up_addr)
  );

  ddm_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk(clk),
    .we(wr_en),
    .waddr(wr_addr),
    .wdata(pixels.pixel),
    .re(in_fire),
    .raddr_a(rd_right_addr),
    .raddr_b(rd_up_addr),
    .rdata_a(q_right),
    .rdata_b(q_up)
  );

  // handshake chain: read stage, difference stage, output register
  logic out_valid, c_valid, b_valid;
  logic out_free, c_ready, b_go;

  ddm_pos_t                     b_info;
  logic signed [PIXEL_BITS-1:0] b_pixel;

  assign out_free     = !out_valid || results.ready;
  assign c_ready      = !c_valid || out_free;
  assign b_go         = b_valid && (!b_info.has_out || c_ready);
  assign pixels.ready = !b_valid || b_go;
  assign in_fire      = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (in_fire) b_valid <= pos_info.advance;
    else if (b_go) b_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_info  <= pos_info;
      b_pixel <= pixels.kind ? '0 : pixels.pixel;
    end
  end

  // window over the output row; tap k of (read data, win) is gap-ahead minus k
  logic [PIXEL_BITS-1:0] win [WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (b_go) begin
      win[0] <= q_right;
      for (int k = 1; k < WIN_DEPTH; k++) win[k] <= win[k-1];
    end
  end

  logic [IW-1:0]         ctr_idx, left_idx;
  logic signed [DW-1:0]  ctr_x, left_x, right_x, up_x, pix_x;
  logic signed [DW-1:0]  vert, hori;

  always_comb begin
    ctr_idx  = IW'(gap_eff) - IW'(1);
    left_idx = IW'({gap_eff, 1'b0}) - IW'(1);
    ctr_x    = DW'($signed(win[ctr_idx[RING_BITS-1:0]]));
    left_x   = DW'($signed(win[left_idx[RING_BITS-1:0]]));
    right_x  = DW'($signed(q_right));
    up_x     = DW'($signed(q_up));
    pix_x    = DW'(b_pixel);
    vert     = (ctr_x <<< 1) - up_x - pix_x;
    hori     = (ctr_x <<< 1) - right_x - left_x;
  end

  ddm_pos_t             c_info;
  logic signed [DW-1:0] c_vert, c_hori;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (b_go && b_info.has_out) c_valid <= 1'b1;
    else if (out_free) c_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (b_go && b_info.has_out) begin
      c_info <= b_info;
      c_vert <= vert;
      c_hori <= hori;
    end
  end

  logic [DW-1:0]        mag_v, mag_h;
  logic                 pick_v;
  logic signed [DW-1:0] sel;

  always_comb begin
    mag_v  = c_vert[DW-1] ? DW'(-c_vert) : DW'(c_vert);
    mag_h  = c_hori[DW-1] ? DW'(-c_hori) : DW'(c_hori);
    pick_v = strong_mode ? (mag_v > mag_h) : (mag_v < mag_h);
    if (!c_info.border_ok) sel = '0;
    else if (pick_v) sel = c_vert;
    else sel = c_hori;
  end

  logic [OUT_BITS-1:0]  out_row, out_col;
  logic signed [DW-1:0] out_diff;
  logic                 out_fe;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (c_valid && out_free) out_valid <= 1'b1;
    else if (out_free) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (c_valid && out_free) begin
      out_row  <= c_info.row;
      out_col  <= c_info.col;
      out_diff <= sel;
      out_fe   <= c_info.frame_end;
    end
  end

  assign results.valid      = out_valid;
  assign results.out_row    = out_row;
  assign results.out_col    = out_col;
  assign results.diff_value = out_diff;
  assign results.frame_end  = out_fe;

endmodule

// ----- rtl/core/ddm_checker.sv -----
module ddm_checker #(
  parameter int PIXEL_BITS = 16,
  localparam int DW = PIXEL_BITS + 2
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [9:0]           out_row,
  input logic [9:0]           out_col,
  input logic signed [DW-1:0] diff_value,
  input logic                 frame_end
);

  // largest magnitude that 2p minus two pixels can reach
  localparam logic signed [DW-1:0] HI = {1'b0, {PIXEL_BITS{1'b1}}, 1'b0};

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(diff_value) && $stable(frame_end))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (diff_value != '0) |-> (out_row != '0) && (out_col != '0))
    else $error("nonzero difference on the top or left border");

  a_diff_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (diff_value <= HI) && (diff_value >= -HI))
    else $error("difference out of range");

endmodule

bind directional_diff_map ddm_checker #(
  .PIXEL_BITS(PIXEL_BITS)
) u_ddm_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(pixels.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_row(results.out_row),
  .out_col(results.out_col),
  .diff_value(results.diff_value),
  .frame_end(results.frame_end)
);
